### rtl/delimited_text_to_csv_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimited text to CSV block
// ----------------------------------------------------------------------------
`ifndef DELIMITED_TEXT_TO_CSV_ASSERT_SVH
`define DELIMITED_TEXT_TO_CSV_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define DTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication
`define DTC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/dtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared constants, types and helpers of the delimited text to CSV block.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int MAX_FIELD_BYTES   = 256;
    localparam int MAX_PATTERN_BYTES = 8;
    localparam int OUT_WORD_BYTES    = 16;

    localparam int FIELD_AW   = $clog2(MAX_FIELD_BYTES);
    localparam int LEN_W      = $clog2(MAX_FIELD_BYTES + 1);
    localparam int EXT_W      = LEN_W + 1;
    localparam int WIN_AW     = $clog2(MAX_PATTERN_BYTES);
    localparam int PLEN_W     = 4;
    localparam int CNT_W      = $clog2(OUT_WORD_BYTES + 1);
    localparam int WORD_AW    = $clog2(OUT_WORD_BYTES);
    localparam int PAT_W      = 8 * MAX_PATTERN_BYTES;
    localparam int CFG_DW     = 64;
    localparam int CFG_AW     = 6;
    localparam int OUT_BITS   = 8 * OUT_WORD_BYTES + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int CNT_LSB    = 8 * OUT_WORD_BYTES;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [7:0] RST_DELIM = 8'h09;

    typedef enum logic [2:0] {
        REG_DELIM = 3'd0,
        REG_QMODE = 3'd1,
        REG_CRPAT = 3'd2,
        REG_CRLEN = 3'd3,
        REG_LFPAT = 3'd4,
        REG_LFLEN = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        QM_MIN      = 3'd0,
        QM_ALL      = 3'd1,
        QM_NONEMPTY = 3'd2,
        QM_BORDER   = 3'd3,
        QM_SPACE    = 3'd4
    } qmode_t;

    typedef enum logic [2:0] {
        PUSH_COMMA = 3'd0,
        PUSH_QUOTE = 3'd1,
        PUSH_DATA  = 3'd2,
        PUSH_CR    = 3'd3,
        PUSH_LF    = 3'd4
    } push_sel_t;

    typedef struct packed {
        logic [7:0]        delim;
        logic [2:0]        qmode;
        logic [PAT_W-1:0]  cr_pat;
        logic [PLEN_W-1:0] cr_len;
        logic [PAT_W-1:0]  lf_pat;
        logic [PLEN_W-1:0] lf_len;
    } cfg_t;

    typedef struct packed {
        logic      store;
        logic      run_start;
        logic      run_field;
        logic      pass_init;
        logic      pass_run;
        logic      pass_lf;
        logic      pass_end;
        logic      ei_clr;
        logic      ei_inc;
        logic      rd_emit;
        logic      push;
        push_sel_t push_sel;
        logic      flush;
        logic      field_clr;
    } cmd_t;

    typedef struct packed {
        logic in_eoi;
        logic in_delim;
        logic in_cr;
        logic in_lf;
        logic pass_done;
        logic quoted;
        logic ei_end;
        logic data_quote;
        logic push_ok;
        logic flush_ok;
        logic pack_empty;
    } stat_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

### rtl/delimited_text_to_csv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_text_to_csv
// Converts delimited text into CSV with RFC 4180 style field quoting.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transaction in s_tdata; s_tuser[0] set
// flushes an open final field and the byte is ignored.
// Output stream: 16-byte words; m_tdata holds the bytes and the byte count,
// m_tlast marks the last word of the run caused by one input transaction,
// m_tuser[0] flags a truncated field. A run can be empty (no words).
// Config: APB registers at 8*i, written by the user only while the block is
// idle; the block does not enforce it. Throughput: plain field bytes are
// taken one per cycle. A field end walks the 256-byte field RAM three times:
// a CR and an LF replace pass, each over the single read port with an 8-byte
// window, then emission, which reads each byte and then pushes it, with a
// second quote pushed after a quote byte.
// Stall: words wait in the output register; bytes keep packing until 16 are
// held, then the sequencer waits. s_tready is low while a run is built.
// Reset: line state, field length and packer count clear at once; the field
// RAM needs no clearing, only written entries are read.
// ----------------------------------------------------------------------------
module delimited_text_to_csv (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // in_byte
    input  logic [0:0]                      s_tuser,  // end_of_input
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_bytes_low, out_bytes_high, out_count, zero pad
    output logic [dtc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser,  // field_overflow
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dtc_pkg::CFG_AW-1:0]      paddr,
    input  logic [dtc_pkg::CFG_DW-1:0]      pwdata,
    output logic [dtc_pkg::CFG_DW-1:0]      prdata,
    output logic                            pready
);
    import dtc_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t st;
    logic  ovf;

    dtc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dtc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .st       (st),
        .in_byte  (s_tdata),
        .in_eoi   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_ovf    (ovf)
    );

    assign m_tuser = ovf;

`include "delimited_text_to_csv_assert.svh"

    `DTC_ASSERT_IMPLY(a_word_count, m_tvalid, (m_tdata[CNT_LSB +: CNT_W] != '0) && (m_tdata[CNT_LSB +: CNT_W] <= CNT_W'(OUT_WORD_BYTES)), "word byte count out of range")
    `DTC_ASSERT_IMPLY(a_inner_full, m_tvalid && !m_tlast, m_tdata[CNT_LSB +: CNT_W] == CNT_W'(OUT_WORD_BYTES), "non-final word not full")
    `DTC_ASSERT_IMPLY(a_idle_empty, s_tready, st.pack_empty, "packer holds bytes while idle")

endmodule

### rtl/dtc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dtc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_cfg
// APB register file: delimiter, quote mode and the two replace patterns.
// ----------------------------------------------------------------------------
module dtc_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dtc_pkg::CFG_AW-1:0] paddr,
    input  logic [dtc_pkg::CFG_DW-1:0] pwdata,
    output logic [dtc_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output dtc_pkg::cfg_t              cfg
);
    import dtc_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_DELIM: cfg_next.delim  = pwdata[7:0];
                REG_QMODE: cfg_next.qmode  = pwdata[2:0];
                REG_CRPAT: cfg_next.cr_pat = pwdata[PAT_W-1:0];
                REG_CRLEN: cfg_next.cr_len = pwdata[PLEN_W-1:0];
                REG_LFPAT: cfg_next.lf_pat = pwdata[PAT_W-1:0];
                REG_LFLEN: cfg_next.lf_len = pwdata[PLEN_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DELIM: prdata = CFG_DW'(cfg_reg.delim);
            REG_QMODE: prdata = CFG_DW'(cfg_reg.qmode);
            REG_CRPAT: prdata = CFG_DW'(cfg_reg.cr_pat);
            REG_CRLEN: prdata = CFG_DW'(cfg_reg.cr_len);
            REG_LFPAT: prdata = CFG_DW'(cfg_reg.lf_pat);
            REG_LFLEN: prdata = CFG_DW'(cfg_reg.lf_len);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // delimiter sits in the top byte of the packed struct
            cfg_reg <= cfg_t'({RST_DELIM, {($bits(cfg_t) - 8){1'b0}}});
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/dtc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_datapath
// Field buffer, in-place replace passes, field scan flags and word packer.
// ----------------------------------------------------------------------------
module dtc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dtc_pkg::cfg_t                   cfg,
    input  dtc_pkg::cmd_t                   cmd,
    output dtc_pkg::stat_t                  st,
    input  logic [7:0]                      in_byte,
    input  logic                            in_eoi,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic                            m_ovf
);
    import dtc_pkg::*;

    // field state
    logic [LEN_W-1:0] len_reg, len_next;
    logic             trunc_reg, trunc_next;
    logic             run_ovf_reg, run_ovf_next;
    logic             hit_reg, hit_next;
    logic             aq_reg, aq_next, ac_reg, ac_next, as_reg, as_next;
    logic             fsp_reg, fsp_next, lsp_reg, lsp_next;

    // replace pass engine
    logic [LEN_W-1:0]  rd_reg, rd_next, fa_reg, fa_next;
    logic [LEN_W-1:0]  got_reg, got_next, wr_reg, wr_next;
    logic              pend_reg, pend_next;
    logic [WIN_AW-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        win_reg [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0]  ei_reg, ei_next;

    // packer and output register
    logic [7:0]             acc_reg [OUT_WORD_BYTES];
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   mv_reg, mv_next;
    logic [OUT_TDATA_W-1:0] md_reg, md_next;
    logic                   ml_reg, ml_next, mo_reg, mo_next;

    logic [PAT_W-1:0]  pat;
    logic [PLEN_W-1:0] plen_raw, plen;
    logic [7:0]        repl;
    logic [EXT_W-1:0]  rd_plen;
    logic              cmp_ok, match, ready, issue;
    logic              ram_we, ram_re;
    logic [FIELD_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              full_field, border, quoted;
    logic [7:0]        push_byte;
    logic              out_free, pack_full, xfer_full, xfer_last, xfer;

    assign pat      = cmd.pass_lf ? cfg.lf_pat : cfg.cr_pat;
    assign plen_raw = cmd.pass_lf ? cfg.lf_len : cfg.cr_len;
    assign plen     = (plen_raw > PLEN_W'(MAX_PATTERN_BYTES)) ?
                      PLEN_W'(MAX_PATTERN_BYTES) : plen_raw;
    assign repl     = cmd.pass_lf ? CH_LF : CH_CR;
    assign rd_plen  = {1'b0, rd_reg} + EXT_W'(plen);

    always_comb begin
        cmp_ok = 1'b1;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            if ((PLEN_W'(k) < plen) &&
                (win_reg[WIN_AW'(rd_reg[WIN_AW-1:0] + WIN_AW'(k))] != pat[8*k +: 8])) begin
                cmp_ok = 1'b0;
            end
        end
    end

    // a decision needs the whole pattern window, or the end of the field
    assign ready = cmd.pass_run && (got_reg > rd_reg) &&
                   (({1'b0, got_reg} >= rd_plen) || (got_reg == len_reg));
    assign match = (plen != '0) && (rd_plen <= {1'b0, len_reg}) && cmp_ok;
    assign issue = cmd.pass_run && (fa_reg < len_reg) &&
                   ((fa_reg - rd_reg) < LEN_W'(MAX_PATTERN_BYTES));

    assign full_field = len_reg[LEN_W-1];
    assign ram_we     = (cmd.store && !full_field) || ready;
    assign ram_waddr  = cmd.store ? len_reg[FIELD_AW-1:0] : wr_reg[FIELD_AW-1:0];
    assign ram_wdata  = cmd.store ? in_byte :
                        (match ? repl : win_reg[rd_reg[WIN_AW-1:0]]);
    assign ram_re     = issue || cmd.rd_emit;
    assign ram_raddr  = issue ? fa_reg[FIELD_AW-1:0] : ei_reg[FIELD_AW-1:0];

    dtc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FIELD_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        len_next       = len_reg;
        trunc_next     = trunc_reg;
        run_ovf_next   = run_ovf_reg;
        hit_next       = hit_reg;
        aq_next        = aq_reg;
        ac_next        = ac_reg;
        as_next        = as_reg;
        fsp_next       = fsp_reg;
        lsp_next       = lsp_reg;
        rd_next        = rd_reg;
        fa_next        = fa_reg;
        got_next       = got_reg;
        wr_next        = wr_reg;
        pend_next      = issue;
        pend_addr_next = fa_reg[WIN_AW-1:0];
        ei_next        = ei_reg;

        if (cmd.store) begin
            if (full_field) begin
                trunc_next = 1'b1;
            end else begin
                len_next = len_reg + 1'b1;
            end
        end
        if (cmd.run_start) begin
            run_ovf_next = cmd.run_field && trunc_reg;
            hit_next     = 1'b0;
        end
        if (issue) begin
            fa_next = fa_reg + 1'b1;
        end
        if (pend_reg) begin
            got_next = got_reg + 1'b1;
        end
        if (ready) begin
            wr_next = wr_reg + 1'b1;
            rd_next = match ? rd_plen[LEN_W-1:0] : rd_reg + 1'b1;
            if (match) begin
                hit_next = 1'b1;
            end
            if (cmd.pass_lf) begin
                if (ram_wdata == CH_QUOTE) aq_next = 1'b1;
                if (ram_wdata == CH_COMMA) ac_next = 1'b1;
                if (is_space(ram_wdata))   as_next = 1'b1;
                if (wr_reg == '0)          fsp_next = is_space(ram_wdata);
                lsp_next = is_space(ram_wdata);
            end
        end
        if (cmd.pass_end) begin
            len_next = wr_reg;
        end
        if (cmd.pass_init) begin
            rd_next   = '0;
            fa_next   = '0;
            got_next  = '0;
            wr_next   = '0;
            pend_next = 1'b0;
            if (cmd.pass_lf) begin
                aq_next  = 1'b0;
                ac_next  = 1'b0;
                as_next  = 1'b0;
                fsp_next = 1'b0;
                lsp_next = 1'b0;
            end
        end
        if (cmd.field_clr) begin
            len_next   = '0;
            trunc_next = 1'b0;
        end
        if (cmd.ei_clr) begin
            ei_next = '0;
        end else if (cmd.ei_inc) begin
            ei_next = ei_reg + 1'b1;
        end
    end

    assign border = (len_reg != '0) && (fsp_reg || lsp_reg);

    always_comb begin
        quoted = hit_reg || aq_reg || ac_reg;
        case (qmode_t'(cfg.qmode))
            QM_ALL:      quoted = 1'b1;
            QM_NONEMPTY: if (len_reg != '0) quoted = 1'b1;
            QM_BORDER:   if (border) quoted = 1'b1;
            QM_SPACE:    if (as_reg) quoted = 1'b1;
            default:     quoted = hit_reg || aq_reg || ac_reg;
        endcase
    end

    always_comb begin
        case (cmd.push_sel)
            PUSH_COMMA: push_byte = CH_COMMA;
            PUSH_QUOTE: push_byte = CH_QUOTE;
            PUSH_DATA:  push_byte = ram_rdata;
            PUSH_CR:    push_byte = CH_CR;
            PUSH_LF:    push_byte = CH_LF;
            default:    push_byte = CH_COMMA;
        endcase
    end

    // a full word leaves only once another byte shows it is not the last
    assign out_free  = !mv_reg || m_tready;
    assign pack_full = (cnt_reg == CNT_W'(OUT_WORD_BYTES));
    assign xfer_full = cmd.push && pack_full && out_free;
    assign xfer_last = cmd.flush && (cnt_reg != '0) && out_free;
    assign xfer      = xfer_full || xfer_last;

    always_comb begin
        cnt_next = cnt_reg;
        mv_next  = mv_reg && !m_tready;
        md_next  = md_reg;
        ml_next  = ml_reg;
        mo_next  = mo_reg;
        if (xfer) begin
            cnt_next = '0;
            mv_next  = 1'b1;
            md_next  = '0;
            for (int k = 0; k < OUT_WORD_BYTES; k++) begin
                if (CNT_W'(k) < cnt_reg) begin
                    md_next[8*k +: 8] = acc_reg[k];
                end
            end
            md_next[CNT_LSB +: CNT_W] = cnt_reg;
            ml_next = xfer_last;
            mo_next = run_ovf_reg;
        end else if (cmd.push && !pack_full) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            win_reg[pend_addr_reg] <= ram_rdata;
        end
        if (cmd.push && !pack_full) begin
            acc_reg[cnt_reg[WORD_AW-1:0]] <= push_byte;
        end
        pend_addr_reg <= pend_addr_next;
        md_reg        <= md_next;
        ml_reg        <= ml_next;
        mo_reg        <= mo_next;
        rd_reg        <= rd_next;
        fa_reg        <= fa_next;
        got_reg       <= got_next;
        wr_reg        <= wr_next;
        ei_reg        <= ei_next;
        aq_reg        <= aq_next;
        ac_reg        <= ac_next;
        as_reg        <= as_next;
        fsp_reg       <= fsp_next;
        lsp_reg       <= lsp_next;
        hit_reg       <= hit_next;
        run_ovf_reg   <= run_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            trunc_reg <= 1'b0;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            len_reg   <= len_next;
            trunc_reg <= trunc_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_ovf    = mo_reg;

    assign st.in_eoi     = in_eoi;
    assign st.in_delim   = (in_byte == cfg.delim);
    assign st.in_cr      = (in_byte == CH_CR);
    assign st.in_lf      = (in_byte == CH_LF);
    assign st.pass_done  = (rd_reg == len_reg);
    assign st.quoted     = quoted;
    assign st.ei_end     = (ei_reg == len_reg);
    assign st.data_quote = (ram_rdata == CH_QUOTE);
    assign st.push_ok    = !pack_full;
    assign st.flush_ok   = (cnt_reg == '0) || out_free;
    assign st.pack_empty = (cnt_reg == '0);

endmodule

### rtl/dtc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_ctrl
// Sequencer: byte intake, replace passes, field emission and word flush.
// ----------------------------------------------------------------------------
module dtc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  dtc_pkg::stat_t st,
    output dtc_pkg::cmd_t  cmd
);
    import dtc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CRP   = 11'b00000000010,
        S_LFP   = 11'b00000000100,
        S_COMMA = 11'b00000001000,
        S_OQ    = 11'b00000010000,
        S_DRD   = 11'b00000100000,
        S_DWR   = 11'b00001000000,
        S_DQ    = 11'b00010000000,
        S_CQ    = 11'b00100000000,
        S_TERM  = 11'b01000000000,
        S_FLUSH = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ls_reg, ls_next;     // output at line start
    logic   open_reg, open_next; // input line open
    logic   pcr_reg, pcr_next;   // previous byte was CR
    logic   tcr_reg, tcr_next, tlf_reg, tlf_next;
    logic   endl_reg, endl_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ls_next    = ls_reg;
        open_next  = open_reg;
        pcr_next   = pcr_reg;
        tcr_next   = tcr_reg;
        tlf_next   = tlf_reg;
        endl_next  = endl_reg;
        cmd        = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    tcr_next  = 1'b0;
                    tlf_next  = 1'b0;
                    endl_next = 1'b1;
                    if (st.in_eoi) begin
                        if (open_reg) begin
                            cmd.run_start = 1'b1;
                            cmd.run_field = 1'b1;
                            cmd.pass_init = 1'b1;
                            state_next    = S_CRP;
                        end
                        open_next = 1'b0;
                        pcr_next  = 1'b0;
                    end else if (st.in_delim) begin
                        cmd.run_start = 1'b1;
                        cmd.run_field = 1'b1;
                        cmd.pass_init = 1'b1;
                        state_next    = S_CRP;
                        endl_next     = 1'b0;
                        open_next     = 1'b1;
                        pcr_next      = 1'b0;
                    end else if (st.in_cr) begin
                        cmd.run_start = 1'b1;
                        cmd.run_field = 1'b1;
                        cmd.pass_init = 1'b1;
                        state_next    = S_CRP;
                        tcr_next      = 1'b1;
                        open_next     = 1'b0;
                        pcr_next      = 1'b1;
                    end else if (st.in_lf) begin
                        // LF right after CR goes out alone
                        cmd.run_start = 1'b1;
                        tlf_next      = 1'b1;
                        if (pcr_reg) begin
                            state_next = S_TERM;
                        end else begin
                            cmd.run_field = 1'b1;
                            cmd.pass_init = 1'b1;
                            state_next    = S_CRP;
                        end
                        open_next = 1'b0;
                        pcr_next  = 1'b0;
                    end else begin
                        cmd.store = 1'b1;
                        open_next = 1'b1;
                        pcr_next  = 1'b0;
                    end
                end
            end
            S_CRP: begin
                if (st.pass_done) begin
                    cmd.pass_end  = 1'b1;
                    cmd.pass_init = 1'b1;
                    cmd.pass_lf   = 1'b1;
                    state_next    = S_LFP;
                end else begin
                    cmd.pass_run = 1'b1;
                end
            end
            S_LFP: begin
                cmd.pass_lf = 1'b1;
                if (st.pass_done) begin
                    cmd.pass_end = 1'b1;
                    state_next   = S_COMMA;
                end else begin
                    cmd.pass_run = 1'b1;
                end
            end
            S_COMMA: begin
                if (ls_reg) begin
                    state_next = S_OQ;
                end else begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_COMMA;
                    if (st.push_ok) state_next = S_OQ;
                end
            end
            S_OQ: begin
                if (!st.quoted) begin
                    cmd.ei_clr = 1'b1;
                    state_next = S_DRD;
                end else begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_QUOTE;
                    if (st.push_ok) begin
                        cmd.ei_clr = 1'b1;
                        state_next = S_DRD;
                    end
                end
            end
            S_DRD: begin
                if (st.ei_end) begin
                    state_next = S_CQ;
                end else begin
                    cmd.rd_emit = 1'b1;
                    state_next  = S_DWR;
                end
            end
            S_DWR: begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_DATA;
                if (st.push_ok) begin
                    if (st.data_quote) begin
                        state_next = S_DQ;
                    end else begin
                        cmd.ei_inc = 1'b1;
                        state_next = S_DRD;
                    end
                end
            end
            S_DQ: begin
                cmd.push     = 1'b1;
                cmd.push_sel = PUSH_QUOTE;
                if (st.push_ok) begin
                    cmd.ei_inc = 1'b1;
                    state_next = S_DRD;
                end
            end
            S_CQ: begin
                if (!st.quoted) begin
                    cmd.field_clr = 1'b1;
                    ls_next       = 1'b0;
                    state_next    = S_TERM;
                end else begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = PUSH_QUOTE;
                    if (st.push_ok) begin
                        cmd.field_clr = 1'b1;
                        ls_next       = 1'b0;
                        state_next    = S_TERM;
                    end
                end
            end
            S_TERM: begin
                if (tcr_reg || tlf_reg) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = tcr_reg ? PUSH_CR : PUSH_LF;
                    if (st.push_ok) begin
                        ls_next    = endl_reg;
                        state_next = S_FLUSH;
                    end
                end else begin
                    ls_next    = endl_reg;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                cmd.flush = 1'b1;
                if (st.flush_ok) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        tcr_reg  <= tcr_next;
        tlf_reg  <= tlf_next;
        endl_reg <= endl_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ls_reg    <= 1'b1;
            open_reg  <= 1'b0;
            pcr_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ls_reg    <= ls_next;
            open_reg  <= open_next;
            pcr_reg   <= pcr_next;
        end
    end

endmodule
